[rtl/queue_from_two_stacks_core_assert.svh]
// ----------------------------------------------------------------------------
// queue_from_two_stacks_core_assert
// assertion macros shared by the queue rtl
// ----------------------------------------------------------------------------
`ifndef QUEUE_FROM_TWO_STACKS_CORE_ASSERT_SVH
`define QUEUE_FROM_TWO_STACKS_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define QFTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qfts assertion failed");

// next-cycle implication, disabled while reset is asserted
`define QFTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("qfts assertion failed");

`endif

[rtl/qfts_pkg.sv]
// ----------------------------------------------------------------------------
// qfts_pkg
// shared constants and types of the two-stack queue
// ----------------------------------------------------------------------------
package qfts_pkg;

    localparam int DEFAULT_DEPTH = 128;
    localparam int DATA_W        = 32;
    localparam int STAT_W        = 2;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [DATA_W-1:0] EMPTY_DATA = '1;
    localparam logic [DATA_W-1:0] ZERO_DATA  = '0;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

endpackage

[rtl/qfts_ram.sv]
// ----------------------------------------------------------------------------
// qfts_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module qfts_ram #(
    parameter int WIDTH = qfts_pkg::DATA_W,
    parameter int DEPTH = qfts_pkg::DEFAULT_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    import qfts_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/queue_from_two_stacks_core.sv]
// ----------------------------------------------------------------------------
// queue_from_two_stacks_core
// fifo queue built from an input stack and an output stack in two rams
// ----------------------------------------------------------------------------
//  channel   dir  ports                        transaction
//  s_        in   s_valid s_ready s_opcode     one enqueue or dequeue
//                 s_value
//  m_        out  m_valid m_ready m_data       one result per input
//                 m_status
//
// enqueue: answered directly from idle. dequeue with a non-empty output stack: ram read,
// then st_rdout. dequeue that refills the output stack: st_xfer reads the n input-stack
// entries, one input ram read per cycle, moves all but the oldest to the output ram, and st_last sends the oldest out.
// reset clears the counts and control state only; the rams need no clearing pass.
// a result waiting in the output register blocks s_ready until taken.
module queue_from_two_stacks_core #(
    parameter int DEPTH = qfts_pkg::DEFAULT_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic signed [qfts_pkg::DATA_W-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [qfts_pkg::DATA_W-1:0] m_data,
    output logic [qfts_pkg::STAT_W-1:0]       m_status
);
    import qfts_pkg::*;

`include "queue_from_two_stacks_core_assert.svh"

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_XFER  = 4'b0010,
        ST_LAST  = 4'b0100,
        ST_RDOUT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  in_cnt_reg, in_cnt_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic              pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    status_t           m_status_reg, m_status_next;

    logic              m_load;
    logic              out_free;

    logic              in_we, in_re, out_we, out_re;
    logic [AW-1:0]     in_wr_addr, in_rd_addr, out_wr_addr, out_rd_addr;
    logic [DATA_W-1:0] in_rdata, out_rdata;

    logic [CNT_W-1:0]  in_cnt_dec, out_cnt_dec;

    logic              xfer_start;
    logic              in_drained;

    assign in_cnt_dec  = in_cnt_reg - CNT_ONE;
    assign out_cnt_dec = out_cnt_reg - CNT_ONE;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;

    assign in_wr_addr  = in_cnt_reg[AW-1:0];
    assign in_rd_addr  = in_cnt_dec[AW-1:0];
    assign out_wr_addr = out_cnt_reg[AW-1:0];
    assign out_rd_addr = out_cnt_dec[AW-1:0];

    qfts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_in_ram (
        .aclk    (aclk),
        .we      (in_we),
        .wr_addr (in_wr_addr),
        .wr_data (s_value),
        .re      (in_re),
        .rd_addr (in_rd_addr),
        .rd_data (in_rdata)
    );

    // transfer writes the word read from the input ram in the previous cycle
    qfts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_out_ram (
        .aclk    (aclk),
        .we      (out_we),
        .wr_addr (out_wr_addr),
        .wr_data (in_rdata),
        .re      (out_re),
        .rd_addr (out_rd_addr),
        .rd_data (out_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        in_cnt_next   = in_cnt_reg;
        out_cnt_next  = out_cnt_reg;
        pend_next     = 1'b0;
        in_we         = 1'b0;
        in_re         = 1'b0;
        out_we        = 1'b0;
        out_re        = 1'b0;
        m_load        = 1'b0;
        m_data_next   = ZERO_DATA;
        m_status_next = STAT_OK;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_opcode == OP_ENQUEUE) begin
                        m_load = 1'b1;
                        if (in_cnt_reg == CNT_FULL) begin
                            m_status_next = STAT_FULL;
                        end else begin
                            in_we       = 1'b1;
                            in_cnt_next = in_cnt_reg + CNT_ONE;
                        end
                    end else if (out_cnt_reg != '0) begin
                        out_re       = 1'b1;
                        out_cnt_next = out_cnt_dec;
                        state_next   = ST_RDOUT;
                    end else if (in_cnt_reg == '0) begin
                        m_load        = 1'b1;
                        m_data_next   = EMPTY_DATA;
                        m_status_next = STAT_EMPTY;
                    end else begin
                        state_next = ST_XFER;
                    end
                end
            end
            ST_XFER: begin
                in_re       = 1'b1;
                in_cnt_next = in_cnt_dec;
                pend_next   = 1'b1;
                if (pend_reg) begin
                    out_we       = 1'b1;
                    out_cnt_next = out_cnt_reg + CNT_ONE;
                end
                // the oldest entry is read last and goes straight out
                if (in_cnt_reg == CNT_ONE) begin
                    pend_next  = 1'b0;
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                if (out_free) begin
                    m_load      = 1'b1;
                    m_data_next = in_rdata;
                    state_next  = ST_IDLE;
                end
            end
            ST_RDOUT: begin
                if (out_free) begin
                    m_load      = 1'b1;
                    m_data_next = out_rdata;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_data_reg   <= m_data_next;
            m_status_reg <= m_status_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;

    assign xfer_start = (state_reg == ST_IDLE) && (state_next == ST_XFER);
    assign in_drained = (in_cnt_reg == '0) && !pend_reg;

    `QFTS_ASSERT_IMPL(a_in_cnt_bound, aclk, aresetn, 1'b1, in_cnt_reg <= CNT_FULL)
    `QFTS_ASSERT_IMPL(a_out_cnt_bound, aclk, aresetn, 1'b1, out_cnt_reg <= CNT_FULL)
    `QFTS_ASSERT_NEXT(a_xfer_needs_empty, aclk, aresetn, xfer_start, out_cnt_reg == '0)
    `QFTS_ASSERT_IMPL(a_last_drained, aclk, aresetn, state_reg == ST_LAST, in_drained)

endmodule
